// ===== src/lpd_pkg.sv =====
// Shared declarations for the length-prefixed record deframer.
// Holds parameter defaults, phase codes and the result record type.
// No dependencies.
package lpd_pkg;

    // Parameter defaults.
    localparam int unsigned DEF_RADIX     = 128;
    localparam int unsigned DEF_LEN_WIDTH = 32;

    // Width of the record_length output port.
    localparam int unsigned RECLEN_W = 32;

    // Phase codes of the deframing state machine.
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_DIGITS  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // One result as it leaves the decode stage.
    typedef struct packed {
        logic                valid;
        logic [7:0]          payload_byte;
        logic                is_payload;
        logic                last_of_record;
        logic [RECLEN_W-1:0] record_length;
        logic                length_overflow;
    } t_lpd_res;

endpackage : lpd_pkg

// ===== src/lpd_core.sv =====
// Decode stage of the length-prefixed record deframer: the record state and
// the single-pass next-state and result logic for one stream byte.
// Depends on lpd_pkg.
module lpd_core #(
    parameter int unsigned RADIX     = lpd_pkg::DEF_RADIX,
    parameter int unsigned LEN_WIDTH = lpd_pkg::DEF_LEN_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_resync,
    output lpd_pkg::t_lpd_res o_res
);
    import lpd_pkg::*;

    // The length counter is at most 32 bits wide.
    localparam int unsigned CW = (LEN_WIDTH > 32) ? 32 : LEN_WIDTH;
    // accum * RADIX + digit stays below 2^(CW+9) for RADIX up to 256.
    localparam int unsigned PW = CW + 9;
    localparam logic [CW-1:0] LEN_MAX = {CW{1'b1}};

    logic [1:0]    r_phase,  n_phase;
    logic [7:0]    r_digits, n_digits;
    logic [CW-1:0] r_accum,  n_accum;
    logic [CW-1:0] r_bytes,  n_bytes;
    logic          r_ovf,    n_ovf;

    logic [PW-1:0] w_prod;
    logic          w_sat;
    logic [CW-1:0] w_accum;
    logic          w_last;
    logic          do_hdr;

    assign w_prod  = {9'd0, r_accum} * PW'(RADIX) + PW'(i_byte);
    assign w_sat   = w_prod > PW'(LEN_MAX);
    assign w_accum = w_sat ? LEN_MAX : w_prod[CW-1:0];
    assign w_last  = r_bytes <= CW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_accum  = r_accum;
        n_bytes  = r_bytes;
        n_ovf    = r_ovf;
        do_hdr   = 1'b0;
        o_res    = '0;

        if (i_fire) begin
            if (i_resync) begin
                do_hdr = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_DIGITS: begin
                        n_accum  = w_accum;
                        n_ovf    = r_ovf | w_sat;
                        n_digits = r_digits - 8'd1;
                        if (n_digits == 8'd0) begin
                            if (w_accum == '0) begin
                                // A length of zero closes the record with a marker.
                                n_phase = PH_HEADER;
                                n_accum = '0;
                                n_bytes = '0;
                                n_ovf   = 1'b0;
                                o_res.valid          = 1'b1;
                                o_res.last_of_record = 1'b1;
                            end else begin
                                n_bytes = w_accum;
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        o_res.valid           = 1'b1;
                        o_res.payload_byte    = i_byte;
                        o_res.is_payload      = 1'b1;
                        o_res.last_of_record  = w_last;
                        o_res.record_length   = RECLEN_W'(r_accum);
                        o_res.length_overflow = r_ovf;
                        if (w_last) begin
                            n_bytes = '0;
                            n_phase = PH_HEADER;
                        end else begin
                            n_bytes = r_bytes - CW'(1);
                        end
                    end
                    default: begin
                        do_hdr = 1'b1;
                    end
                endcase
            end

            if (do_hdr) begin
                n_accum  = '0;
                n_bytes  = '0;
                n_ovf    = 1'b0;
                n_digits = i_byte;
                if (i_byte == 8'd0) begin
                    n_phase = PH_HEADER;
                    o_res.valid          = 1'b1;
                    o_res.last_of_record = 1'b1;
                end else begin
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_digits <= '0;
            r_accum  <= '0;
            r_bytes  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_accum  <= n_accum;
            r_bytes  <= n_bytes;
            r_ovf    <= n_ovf;
        end
    end

endmodule : lpd_core

// ===== src/length_prefixed_deframer.sv =====
// Top level of the length-prefixed record deframer: input register, decode
// stage and result register with valid/stall handshakes on both sides.
// Depends on lpd_pkg and lpd_core.
//
// The block takes one byte of a stream of back-to-back records in each
// transaction. A record is a digit-count byte n, then n length digits in
// radix RADIX (most significant first), then as many payload bytes as that
// length. Every payload byte comes out as one result transaction carrying
// the byte, the record length, an overflow flag and a last-of-record mark;
// a record of length zero gives a single marker with is_payload low. Header
// and digit bytes give no result. The length counter is min(LEN_WIDTH, 32)
// bits wide and saturates, flagging overflow for the rest of that record.
// Raising i_resync with a byte makes that byte a fresh header and drops the
// record in progress without a last mark. The block accepts one byte in
// every cycle for as long as results are taken. An accepted byte is held in
// the input register and decoded from there, and its result is written to
// the result register, from which it is offered. All of the decoding
// happens in a single pass between those two registers. While a result
// waits under stall, the held byte is not decoded and the input is stalled.
module length_prefixed_deframer #(
    parameter int unsigned RADIX     = lpd_pkg::DEF_RADIX,
    parameter int unsigned LEN_WIDTH = lpd_pkg::DEF_LEN_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Byte stream in.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_resync,
    // Results out.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_is_payload,
    output logic                         o_last_of_record,
    output logic [lpd_pkg::RECLEN_W-1:0] o_record_length,
    output logic                         o_length_overflow
);
    import lpd_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_resync;

    // Result register.
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_is_payload;
    logic                r_out_last;
    logic [RECLEN_W-1:0] r_out_length;
    logic                r_out_ovf;

    logic     fire;
    t_lpd_res res;

    // The held byte is decoded once the result register is free or is
    // being emptied in this cycle, so only a stalled waiting result blocks it.
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte   <= i_in_byte;
            r_in_resync <= i_resync;
        end
    end

    lpd_core #(
        .RADIX     (RADIX),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_resync (r_in_resync),
        .o_res    (res)
    );

    // A decoded byte that gives no result simply leaves the register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res.valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_byte       <= res.payload_byte;
            r_out_is_payload <= res.is_payload;
            r_out_last       <= res.last_of_record;
            r_out_length     <= res.record_length;
            r_out_ovf        <= res.length_overflow;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_payload_byte    = r_out_byte;
    assign o_is_payload      = r_out_is_payload;
    assign o_last_of_record  = r_out_last;
    assign o_record_length   = r_out_length;
    assign o_length_overflow = r_out_ovf;

endmodule : length_prefixed_deframer

// ===== src/lpd_checker.sv =====
// Port-level checks for the length-prefixed record deframer, and the bind
// that attaches them to the top level.
// Depends on lpd_pkg and length_prefixed_deframer.
module lpd_checker #(
    parameter int unsigned LEN_WIDTH = lpd_pkg::DEF_LEN_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [7:0]                   o_payload_byte,
    input logic                         o_is_payload,
    input logic                         o_last_of_record,
    input logic [lpd_pkg::RECLEN_W-1:0] o_record_length,
    input logic                         o_length_overflow
);
    import lpd_pkg::*;

    localparam int unsigned CW = (LEN_WIDTH > 32) ? 32 : LEN_WIDTH;
    localparam logic [RECLEN_W-1:0] LEN_MAX = RECLEN_W'({CW{1'b1}});

    // A stalled result transaction stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_is_payload) && $stable(o_last_of_record)
            && $stable(o_record_length) && $stable(o_length_overflow))
        else $error("result changed while stalled");

    // An empty-record marker is a closed record with all fields cleared.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_payload |-> o_last_of_record && o_record_length == '0
            && !o_length_overflow && o_payload_byte == 8'd0)
        else $error("malformed empty-record marker");

    // Payload only flows for records of non-zero length.
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_payload |-> o_record_length != '0)
        else $error("payload with zero record length");

    // A saturated length reads as the counter maximum.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_length_overflow |-> o_record_length == LEN_MAX)
        else $error("overflow flagged without saturated length");

endmodule : lpd_checker

bind length_prefixed_deframer lpd_checker #(
    .LEN_WIDTH (LEN_WIDTH)
) u_lpd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_payload_byte    (o_payload_byte),
    .o_is_payload      (o_is_payload),
    .o_last_of_record  (o_last_of_record),
    .o_record_length   (o_record_length),
    .o_length_overflow (o_length_overflow)
);

// ===== tb/lpd_checker.sv =====
// Scoreboard for the length-prefixed record deframer: watches both byte and result channels.
// Keeps its own deframing state and queues the results that each accepted byte should give.
// Depends on lpd_pkg.
module lpd_scoreboard #(
    parameter int unsigned RADIX     = lpd_pkg::DEF_RADIX,
    parameter int unsigned LEN_WIDTH = lpd_pkg::DEF_LEN_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_resync,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [7:0]                   i_payload_byte,
    input  logic                         i_is_payload,
    input  logic                         i_last_of_record,
    input  logic [lpd_pkg::RECLEN_W-1:0] i_record_length,
    input  logic                         i_length_overflow,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int unsigned COUNT_W = (LEN_WIDTH > 32) ? 32 : LEN_WIDTH;
    localparam logic [63:0] LEN_MAX = (64'd1 << COUNT_W) - 64'd1;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                is_payload;
        logic                last_of_record;
        logic [RECLEN_W-1:0] record_length;
        logic                length_overflow;
    } t_deframed;

    t_deframed   expected_results[$];
    logic [1:0]  phase;
    logic [7:0]  digits_left;
    logic [31:0] length_accum;
    logic [31:0] bytes_left;
    logic        overflow_seen;
    int          mismatches = 0;

    // An empty record gives a single marker and returns to header hunting.
    task automatic emit_marker();
        t_deframed r;
        r                 = '0;
        r.last_of_record  = 1'b1;
        expected_results.push_back(r);
        phase         = PH_HEADER;
        length_accum  = '0;
        bytes_left    = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic sync);
        t_deframed   r;
        logic [63:0] acc;
        if (sync || phase == PH_HEADER || phase > PH_PAYLOAD) begin
            length_accum  = '0;
            bytes_left    = '0;
            overflow_seen = 1'b0;
            if (b == 8'd0) begin
                digits_left = '0;
                emit_marker();
            end else begin
                digits_left = b;
                phase       = PH_DIGITS;
            end
        end else if (phase == PH_DIGITS) begin
            acc = 64'(length_accum) * 64'(RADIX) + 64'(b);
            if (acc > LEN_MAX) begin
                acc           = LEN_MAX;
                overflow_seen = 1'b1;
            end
            length_accum = acc[31:0];
            digits_left  = digits_left - 8'd1;
            if (digits_left == 8'd0) begin
                if (length_accum == 32'd0) begin
                    emit_marker();
                end else begin
                    bytes_left = length_accum;
                    phase      = PH_PAYLOAD;
                end
            end
        end else begin
            r.payload_byte    = b;
            r.is_payload      = 1'b1;
            r.last_of_record  = (bytes_left <= 32'd1);
            r.record_length   = length_accum;
            r.length_overflow = overflow_seen;
            expected_results.push_back(r);
            if (bytes_left <= 32'd1) begin
                bytes_left = '0;
                phase      = PH_HEADER;
            end else begin
                bytes_left = bytes_left - 32'd1;
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deframed want;
        if (!i_rst_n) begin
            phase         = PH_HEADER;
            digits_left   = '0;
            length_accum  = '0;
            bytes_left    = '0;
            overflow_seen = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting: byte %0d",
                           i_payload_byte);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("payload_byte", 64'(want.payload_byte), 64'(i_payload_byte));
                    compare_field("is_payload", 64'(want.is_payload), 64'(i_is_payload));
                    compare_field("last_of_record", 64'(want.last_of_record),
                                  64'(i_last_of_record));
                    compare_field("record_length", 64'(want.record_length),
                                  64'(i_record_length));
                    compare_field("length_overflow", 64'(want.length_overflow),
                                  64'(i_length_overflow));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_in_byte, i_resync);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule : lpd_scoreboard

// ===== tb/tb_length_prefixed_deframer.sv =====
// Top level of the deframer testbench: clock, reset, byte stimulus, result back-pressure
// and the verdict. Depends on lpd_pkg, length_prefixed_deframer and lpd_scoreboard.
module tb_length_prefixed_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RADIX          = lpd_pkg::DEF_RADIX;
    localparam int unsigned LEN_WIDTH      = lpd_pkg::DEF_LEN_WIDTH;
    localparam int          RANDOM_ITEMS   = 450;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;

    // Shapes of record that the random part of the stimulus produces.
    typedef enum {
        REC_WELL_FORMED,
        REC_SATURATING,
        REC_CUT_SHORT,
        REC_NOISE
    } t_record_kind;

    // Back-pressure patterns of the result side.
    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [7:0]                   in_byte   = 8'd0;
    logic                         in_resync = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [7:0]                   payload_byte;
    logic                         is_payload;
    logic                         last_of_record;
    logic [lpd_pkg::RECLEN_W-1:0] record_length;
    logic                         length_overflow;
    int                           fail_count;
    int                           pending;

    // Bookkeeping of the byte sender.
    int burst_left  = 0;
    int sent_items  = 0;
    bit need_resync = 1'b0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    length_prefixed_deframer #(
        .RADIX     (RADIX),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_in_byte         (in_byte),
        .i_resync          (in_resync),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_payload_byte    (payload_byte),
        .o_is_payload      (is_payload),
        .o_last_of_record  (last_of_record),
        .o_record_length   (record_length),
        .o_length_overflow (length_overflow)
    );

    lpd_scoreboard #(
        .RADIX     (RADIX),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_byte         (in_byte),
        .i_resync          (in_resync),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_payload_byte    (payload_byte),
        .i_is_payload      (is_payload),
        .i_last_of_record  (last_of_record),
        .i_record_length   (record_length),
        .i_length_overflow (length_overflow),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Offers one byte and returns once the block has taken it. The sender works in
    // bursts; between bursts valid often drops for a gap, and these gaps land on
    // whatever part of a record happens to be in flight. Valid is left high from one
    // transaction to the next inside a burst, so it is never lowered and raised again
    // within the same time step.
    task automatic send_byte(input logic [7:0] value, input logic sync);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid  <= 1'b1;
        in_byte   <= value;
        in_resync <= sync;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        sent_items++;
    endtask

    // Sends a complete record: digit count, the length in that many radix digits with
    // the most significant first, then the payload itself with random content. A digit
    // count of zero sends the bare header.
    task automatic send_frame(input int unsigned len, input int unsigned ndigits,
                              input logic sync);
        int unsigned scale;
        send_byte(8'(ndigits), sync);
        for (int k = int'(ndigits) - 1; k >= 0; k--) begin
            scale = 1;
            repeat (k) scale *= RADIX;
            send_byte(8'((len / scale) % RADIX), 1'b0);
        end
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Most records are well formed with short payloads; the remainder saturate the
    // length counter, are abandoned part of the way through, or are plain noise. Anything
    // that leaves the block out of step makes the next header carry resync.
    task automatic send_random_record();
        t_record_kind kind;
        int unsigned  pick;
        int unsigned  len;
        int unsigned  ndigits;
        int unsigned  span;
        logic         sync;
        pick = $urandom_range(0, 99);
        if (pick < 65) kind = REC_WELL_FORMED;
        else if (pick < 77) kind = REC_SATURATING;
        else if (pick < 90) kind = REC_CUT_SHORT;
        else kind = REC_NOISE;
        sync = need_resync || ($urandom_range(0, 7) == 0);
        case (kind)
            REC_WELL_FORMED: begin
                pick = $urandom_range(0, 99);
                if (pick < 15) len = 0;
                else if (pick < 85) len = $urandom_range(1, 12);
                else if (pick < 97) len = $urandom_range(13, 40);
                else len = $urandom_range(100, 300);
                ndigits = 1;
                span    = RADIX;
                while (len >= span) begin
                    ndigits++;
                    span *= RADIX;
                end
                if ($urandom_range(0, 3) == 0) ndigits += $urandom_range(1, 2);
                // An empty record may also be sent as a zero digit count.
                if (len == 0 && $urandom_range(0, 1) == 0) ndigits = 0;
                send_frame(len, ndigits, sync);
                need_resync = 1'b0;
            end
            REC_SATURATING: begin
                ndigits = $urandom_range(5, 8);
                send_byte(8'(ndigits), sync);
                repeat (ndigits) send_byte(8'($urandom_range(128, 255)), 1'b0);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                need_resync = 1'b1;
            end
            REC_CUT_SHORT: begin
                ndigits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 255)
                                                      : $urandom_range(1, 4);
                send_byte(8'(ndigits), sync);
                repeat ($urandom_range(0, (ndigits < 4) ? ndigits : 4)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                need_resync = 1'b1;
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                need_resync = 1'b1;
            end
        endcase
    endtask

    // Main stimulus: reset, the directed records, the random records and the verdict.
    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero digit count is an empty record on its own.
        send_byte(8'h00, 1'b0);
        // Two digits that are both zero also give an empty record.
        send_frame(0, 2, 1'b0);
        // The shortest real record, carrying the top byte value.
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        // A digit above the radix counts at its full value; the long record that
        // results is cut short after two payload bytes.
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        // Resync in the middle of a payload, into a record whose five maximal digits
        // saturate the length counter.
        send_byte(8'h05, 1'b1);
        repeat (5) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b0);
        // Resync with a zero byte drops that record and gives an empty marker.
        send_byte(8'h00, 1'b1);
        // The largest digit count, abandoned after one digit by a resync header.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h3C, 1'b0);

        begin : random_part
            int target;
            target = sent_items + RANDOM_ITEMS;
            while (sent_items < target) send_random_record();
        end
        in_valid <= 1'b0;

        // Wait for every expected result, then give a stray one time to show up.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result-side back-pressure. The receiver moves through stretches of differing
    // stall density, some with no stall at all. Once the sender is well under way it
    // holds off for a long stretch so that the block fills up and stalls its input.
    initial begin : receiver
        t_stall_mode mode;
        int          span;
        bit          held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!held && sent_items >= 80) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog: a run in which no transaction completes on either side for too long
    // has hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule : tb_length_prefixed_deframer

// ===== sim.f =====
src/lpd_pkg.sv
src/lpd_core.sv
src/length_prefixed_deframer.sv
src/lpd_checker.sv
tb/lpd_checker.sv
tb/tb_length_prefixed_deframer.sv
